// ===== hdl/pcibar_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCI BAR emulation package
// Shared types, constants and helpers for the base address register block.
// ----------------------------------------------------------------------------
package pcibar_pkg;

	// Number of BAR slots that the block holds guest-written words for.
	localparam int BAR_SLOTS = 6;
	// Number of setup registers on the configuration port.
	localparam int SETUP_REGS = 6;
	localparam int IDX_W = (BAR_SLOTS > 1) ? $clog2(BAR_SLOTS) : 1;

	localparam int OFFSET_W = 8;
	localparam int SUM_W = OFFSET_W + 1;
	localparam logic [SUM_W-1:0] WINDOW_BASE = SUM_W'(16);
	localparam logic [SUM_W-1:0] WINDOW_END = SUM_W'(16 + 4 * BAR_SLOTS);

	localparam int SETUP_W = 40;
	localparam int CFG_INDEX_W = 3;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_BAR_COUNT = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_BAR0_SETUP = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_BAR5_SETUP = 3'd6;

	// Access commands.
	localparam logic CMD_READ = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// BAR type codes in the setup register.
	localparam logic [1:0] TYPE_IO = 2'd0;
	localparam logic [1:0] TYPE_PREFETCH = 2'd2;
	localparam logic [31:0] FLAG_IO = 32'h0000_0001;
	localparam logic [31:0] FLAG_PREFETCH = 32'h0000_0008;

	localparam logic [2:0] MAX_SIZE = 3'd4;

	typedef struct packed {
		logic command;
		logic [7:0] offset;
		logic [2:0] size;
		logic [31:0] write_data;
	} access_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic forwarded;
	} result_t;

	// Decoded view of one access.
	typedef struct packed {
		logic forwarded;
		logic is_write;
		logic [IDX_W-1:0] idx;
		logic [1:0] lane;
		logic [3:0] byte_en;
		logic [31:0] wdata;
	} decode_t;

	// Guest write committed into the BAR word store.
	typedef struct packed {
		logic en;
		logic [IDX_W-1:0] idx;
		logic [3:0] byte_en;
		logic [31:0] wdata;
	} bar_write_t;

	// Bits that the guest may set, given the size-bits field.
	function automatic logic [31:0] keep_mask(input logic [5:0] hide);
		logic [31:0] m;
		begin
			if (hide[5]) begin
				m = '0;
			end else begin
				m = 32'hFFFF_FFFF << hide[4:0];
			end
			return m;
		end
	endfunction

endpackage

// ===== hdl/pcibar_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCI BAR access decoder
// Window test, BAR index, byte lanes and lane-aligned write data.
// ----------------------------------------------------------------------------
module pcibar_decode (
	input  pcibar_pkg::access_t acc,
	output pcibar_pkg::decode_t dec
);
	import pcibar_pkg::*;

	logic [2:0] len;
	logic [2:0] len_clip;
	logic [2:0] avail;
	logic [SUM_W-1:0] off_ext;
	logic [SUM_W-1:0] rel;
	logic [3:0] len_mask;

	always_comb begin
		len = (acc.size > MAX_SIZE) ? MAX_SIZE : acc.size;
		off_ext = SUM_W'(acc.offset);
		rel = off_ext - WINDOW_BASE;
		avail = MAX_SIZE - 3'(acc.offset[1:0]);
		len_clip = (len > avail) ? avail : len;

		case (len_clip)
			3'd0: len_mask = 4'b0000;
			3'd1: len_mask = 4'b0001;
			3'd2: len_mask = 4'b0011;
			3'd3: len_mask = 4'b0111;
			default: len_mask = 4'b1111;
		endcase

		dec.forwarded = (off_ext < WINDOW_BASE) || (off_ext >= WINDOW_END)
			|| ((off_ext + SUM_W'(len)) > WINDOW_END);
		dec.is_write = (acc.command == CMD_WRITE);
		dec.idx = IDX_W'(rel[SUM_W-1:2]);
		dec.lane = acc.offset[1:0];
		// Bytes that would run past the end of the BAR are already cut off by len_clip.
		dec.byte_en = 4'(len_mask << acc.offset[1:0]);
		dec.wdata = acc.write_data << {acc.offset[1:0], 3'b000};
	end

endmodule

// ===== hdl/pcibar_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCI BAR register file
// Configuration registers, guest-written BAR words and BAR value assembly.
// ----------------------------------------------------------------------------
module pcibar_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [pcibar_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [pcibar_pkg::SETUP_W-1:0] cfg_data,
	input  pcibar_pkg::bar_write_t wr,
	input  logic [pcibar_pkg::IDX_W-1:0] rd_idx,
	output logic [31:0] rd_value
);
	import pcibar_pkg::*;

	logic [2:0] bar_count_q;
	logic [SETUP_W-1:0] setup_q [SETUP_REGS];
	logic [31:0] guest_q [BAR_SLOTS];
	logic [CFG_INDEX_W-1:0] setup_sel;

	assign setup_sel = cfg_index - CFG_BAR0_SETUP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bar_count_q <= '0;
			for (int i = 0; i < SETUP_REGS; i++) begin
				setup_q[i] <= '0;
			end
		end else if (cfg_wr_en) begin
			if (cfg_index == CFG_BAR_COUNT) begin
				bar_count_q <= cfg_data[2:0];
			end else if (cfg_index >= CFG_BAR0_SETUP && cfg_index <= CFG_BAR5_SETUP) begin
				setup_q[setup_sel] <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BAR_SLOTS; i++) begin
				guest_q[i] <= '0;
			end
		end else if (wr.en) begin
			for (int j = 0; j < 4; j++) begin
				if (wr.byte_en[j]) begin
					guest_q[wr.idx][j*8 +: 8] <= wr.wdata[j*8 +: 8];
				end
			end
		end
	end

	logic [SETUP_W-1:0] setup;
	logic [31:0] value;

	always_comb begin
		setup = setup_q[rd_idx];
		value = setup[31:0];
		if (setup[33:32] == TYPE_IO) begin
			value = value | FLAG_IO;
		end else if (setup[33:32] == TYPE_PREFETCH) begin
			value = value | FLAG_PREFETCH;
		end
		value = value | (guest_q[rd_idx] & keep_mask(setup[39:34]));
		// BARs at or past the configured count read as zero.
		if (3'(rd_idx) >= bar_count_q) begin
			value = '0;
		end
		rd_value = value;
	end

endmodule

// ===== hdl/pci_bar_register_emulation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCI BAR register emulation
// Emulates the base address registers of a PCI type-0 configuration header.
// ----------------------------------------------------------------------------
// The block takes one configuration access per clock cycle while it does
// not stall and returns one result for every access, in order: the
// access is captured in an input register, decoded and served by
// byte-lane logic over the six BAR words, and the answer is held in a
// result register until the consumer takes it. Accesses outside
// the BAR window at offsets 0x10 to 0x27 are flagged as forwarded and read
// zero. A write stores its bytes, little-endian, into the guest word of the
// addressed BAR and takes effect for every access that follows it; bytes that
// run past the end of the BAR are dropped. A read returns the configured base
// address, the I/O or prefetchable flag and the guest bits above the size
// field, with bytes past the end of the BAR reading as zero. Configuration
// writes must only be made while no access is in flight.
module pci_bar_register_emulation (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [pcibar_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [pcibar_pkg::SETUP_W-1:0] cfg_data,
	input  logic req_valid,
	output logic req_stall,
	input  pcibar_pkg::access_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output pcibar_pkg::result_t rsp
);
	import pcibar_pkg::*;

	// Input register stage.
	logic valid_s1;
	access_t acc_s1;

	// Result register stage.
	logic valid_s2;
	result_t res_s2;

	decode_t dec;
	bar_write_t wr;
	logic [31:0] bar_value;
	logic s2_free;
	logic advance;
	result_t res;

	// The result register can take a new result when it is empty or when its
	// current result is leaving in this cycle.
	assign s2_free = !valid_s2 || !rsp_stall;
	assign advance = valid_s1 && s2_free;
	assign req_stall = valid_s1 && !s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			acc_s1 <= req;
		end
	end

	pcibar_decode u_decode (
		.acc (acc_s1),
		.dec (dec)
	);

	// The write is committed at the same edge on which the access moves on,
	// so a read right behind it already sees the new word.
	always_comb begin
		wr.en = advance && dec.is_write && !dec.forwarded
			&& (32'(dec.idx) < 32'(BAR_SLOTS));
		wr.idx = dec.idx;
		wr.byte_en = dec.byte_en;
		wr.wdata = dec.wdata;
	end

	pcibar_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.wr        (wr),
		.rd_idx    (dec.idx),
		.rd_value  (bar_value)
	);

	logic [31:0] lane_mask;

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			lane_mask[j*8 +: 8] = {8{dec.byte_en[j]}};
		end
		res.forwarded = dec.forwarded;
		if (dec.forwarded || dec.is_write) begin
			res.read_data = '0;
		end else begin
			res.read_data = (bar_value & lane_mask) >> {dec.lane, 3'b000};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp = res_s2;

endmodule

// ===== tb/pci_bar_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCI BAR emulation checker
// Watches the configuration port and both access channels of the BAR block,
// predicts the answer to every access and compares it with what comes back.
// ----------------------------------------------------------------------------
module pci_bar_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [pcibar_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [pcibar_pkg::SETUP_W-1:0] cfg_data,
	input  logic req_valid,
	input  logic req_stall,
	input  pcibar_pkg::access_t req,
	input  logic rsp_valid,
	input  logic rsp_stall,
	input  pcibar_pkg::result_t rsp,
	output int fail_count,
	output int outstanding
);
	import pcibar_pkg::*;

	// Shadow copy of the configuration and of the guest-written BAR words.
	logic [2:0] bar_count;
	logic [SETUP_W-1:0] bar_setup [BAR_SLOTS];
	logic [31:0] guest_words [BAR_SLOTS];

	// Answers owed by the block, oldest first.
	result_t awaited_answers [$];
	result_t oldest;
	int answers_seen;

	initial begin
		fail_count = 0;
		outstanding = 0;
		answers_seen = 0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch on answer %0d: %s, got %h, expected %h",
			answers_seen, what, got, want);
		fail_count++;
	endtask

	// Value that the guest sees when it reads a whole BAR.
	function automatic logic [31:0] bar_value(input int unsigned slot);
		logic [SETUP_W-1:0] s;
		logic [31:0] v;
		logic [5:0] hide;
		logic [31:0] writable;
		if (slot >= bar_count) begin
			return '0;
		end
		s = bar_setup[slot];
		v = s[31:0];
		hide = s[39:34];
		case (s[33:32])
			TYPE_IO: begin
				v |= FLAG_IO;
			end
			TYPE_PREFETCH: begin
				v |= FLAG_PREFETCH;
			end
			default: begin
			end
		endcase
		writable = (hide >= 6'd32) ? 32'h0 : (32'hFFFF_FFFF << hide);
		return v | (guest_words[slot] & writable);
	endfunction

	// Carries out one access on the shadow state and returns its answer.
	function automatic result_t apply_access(input access_t a);
		result_t r;
		logic [2:0] len;
		logic [8:0] span_end;
		logic [7:0] rel;
		logic [1:0] lane;
		logic [31:0] v;
		int unsigned slot;
		int unsigned i;
		r = '0;
		len = (a.size > MAX_SIZE) ? MAX_SIZE : a.size;
		span_end = {1'b0, a.offset} + {6'd0, len};
		if ({1'b0, a.offset} < WINDOW_BASE || {1'b0, a.offset} >= WINDOW_END
			|| span_end > WINDOW_END) begin
			r.forwarded = 1'b1;
			return r;
		end
		rel = a.offset - WINDOW_BASE[7:0];
		slot = rel[7:2];
		lane = a.offset[1:0];
		// Bytes running past the end of the addressed BAR are cut off.
		if (len > 3'd4 - {1'b0, lane}) begin
			len = 3'd4 - {1'b0, lane};
		end
		if (a.command == CMD_WRITE) begin
			for (i = 0; i < len; i++) begin
				guest_words[slot][8 * (lane + i) +: 8] = a.write_data[8 * i +: 8];
			end
		end else begin
			v = bar_value(slot);
			for (i = 0; i < len; i++) begin
				r.read_data[8 * i +: 8] = v[8 * (lane + i) +: 8];
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bar_count = '0;
			for (int n = 0; n < BAR_SLOTS; n++) begin
				bar_setup[n] = '0;
				guest_words[n] = '0;
			end
			awaited_answers.delete();
			outstanding = 0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == CFG_BAR_COUNT) begin
					bar_count = cfg_data[2:0];
				end else if (cfg_index >= CFG_BAR0_SETUP && cfg_index <= CFG_BAR5_SETUP) begin
					bar_setup[cfg_index - CFG_BAR0_SETUP] = cfg_data;
				end
			end
			if (rsp_valid && !rsp_stall) begin
				if (awaited_answers.size() == 0) begin
					report_mismatch("answer with no access outstanding", rsp.read_data, '0);
				end else begin
					oldest = awaited_answers.pop_front();
					if (rsp.read_data !== oldest.read_data) begin
						report_mismatch("read_data", rsp.read_data, oldest.read_data);
					end
					if (rsp.forwarded !== oldest.forwarded) begin
						report_mismatch("forwarded", 32'(rsp.forwarded), 32'(oldest.forwarded));
					end
				end
				answers_seen++;
			end
			if (req_valid && !req_stall) begin
				awaited_answers.push_back(apply_access(req));
			end
			outstanding = awaited_answers.size();
		end
	end

endmodule

// ===== tb/tb_pci_bar_register_emulation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCI BAR emulation testbench
// Drives configuration accesses into the BAR block under a range of register
// settings and back-pressure patterns; a checker beside it scores the answers.
// ----------------------------------------------------------------------------
module tb_pci_bar_register_emulation;
	import pcibar_pkg::*;

	// Register index past the last setup register; the block must ignore it.
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 3'd7;
	// BAR type codes that the package leaves unnamed.
	localparam logic [1:0] TYPE_MEM = 2'd1;
	localparam logic [1:0] TYPE_SPARE = 2'd3;

	localparam int SETTING_COUNT = 6;
	localparam int ACCESSES_PER_SETTING = 250;
	// Far beyond the slowest legal run.
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [SETUP_W-1:0] cfg_data = '0;
	logic req_valid = 1'b0;
	logic req_stall;
	access_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	result_t rsp;

	int fail_count;
	int outstanding;
	int cycle_count = 0;

	// Percentages of cycles in which the sender holds back and the receiver
	// stalls; changed between the phases of the run.
	int send_idle_pct = 0;
	int rcv_idle_pct = 0;

	// Setting to be loaded by the next call of load_setting.
	logic [2:0] next_count;
	logic [SETUP_W-1:0] next_setup [SETUP_REGS];

	always #5 clk = ~clk;

	pci_bar_register_emulation dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	pci_bar_checker scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	// The receiver decides afresh every cycle whether to stall the answer
	// channel, so stalls land on every stage of the pipeline.
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
	end

	// Watchdog: a hung handshake or an answer that never arrives ends the run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic access_t access_of(input logic command, input logic [7:0] offset,
		input logic [2:0] size, input logic [31:0] write_data);
		access_t a;
		a.command = command;
		a.offset = offset;
		a.size = size;
		a.write_data = write_data;
		return a;
	endfunction

	// Most accesses land in the BAR window with a legal size, so that writes
	// and reads meet on the same registers; the rest cover the whole field range.
	function automatic access_t random_access();
		access_t a;
		a.command = 1'($urandom_range(1));
		a.write_data = $urandom;
		if ($urandom_range(9) < 7) begin
			a.offset = 8'($urandom_range(int'(WINDOW_END) - 1, int'(WINDOW_BASE)));
			a.size = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4, 1));
		end else begin
			a.offset = 8'($urandom_range(255));
			a.size = 3'($urandom_range(7));
		end
		return a;
	endfunction

	// One transfer on the access channel. The sender may hold back first,
	// showing junk on the payload while valid is low. Valid is
	// left high on return, so back-to-back transfers never lower it.
	task automatic send(input access_t a);
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			req <= random_access();
			do begin
				@(posedge clk);
			end while ($urandom_range(99) < send_idle_pct);
		end
		req <= a;
		req_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (req_stall);
	endtask

	// Stops sending and waits until every answer has been taken. The
	// checker's count changes at the rising edge, so it is read at the
	// falling one. It then waits on so that the pipeline can settle.
	task automatic drain();
		req_valid <= 1'b0;
		do begin
			@(negedge clk);
		end while (outstanding != 0);
		repeat (3) @(posedge clk);
	endtask

	// Writes every register, and the unused index as well, while idle.
	// The write enable stays high across the burst and drops once at the end.
	task automatic load_setting();
		drain();
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_BAR_COUNT;
		// Bits above the count field carry noise that must be ignored.
		cfg_data <= {5'($urandom), $urandom, next_count};
		@(posedge clk);
		for (int s = 0; s < SETUP_REGS; s++) begin
			cfg_index <= CFG_BAR0_SETUP + CFG_INDEX_W'(s);
			cfg_data <= next_setup[s];
			@(posedge clk);
		end
		cfg_index <= CFG_SPARE_INDEX;
		cfg_data <= {8'($urandom), $urandom};
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Setting 0 is the all-ones extreme, setting 1 the all-zero one; the
	// others are random, count included.
	task automatic pick_setting(input int which);
		for (int s = 0; s < SETUP_REGS; s++) begin
			case (which)
				0: next_setup[s] = '1;
				1: next_setup[s] = '0;
				default: next_setup[s] = {8'($urandom), $urandom};
			endcase
		end
		case (which)
			0: next_count = 3'd7;
			1: next_count = 3'd0;
			default: next_count = 3'($urandom_range(7));
		endcase
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// First phase: the sender seldom holds back, the receiver often stalls.
		send_idle_pct = 11;
		rcv_idle_pct = 47;

		// Straight out of reset no BAR is emulated, so even a written one
		// reads as zero.
		send(access_of(CMD_READ, 8'h10, 3'd4, '0));
		send(access_of(CMD_WRITE, 8'h14, 3'd4, 32'hFFFF_FFFF));
		send(access_of(CMD_READ, 8'h14, 3'd4, '0));

		// A count above the slot number emulates every BAR. The six BARs
		// cover I/O, memory, prefetchable and the unused type code, and size
		// fields from none through to one that hides every guest bit.
		next_count = 3'd7;
		next_setup[0] = {6'd4, TYPE_IO, 32'h0000_C000};
		next_setup[1] = {6'd20, TYPE_MEM, 32'hFE00_0000};
		next_setup[2] = {6'd13, TYPE_PREFETCH, 32'hA5A5_0000};
		next_setup[3] = {6'd0, TYPE_SPARE, 32'h1234_5670};
		next_setup[4] = {6'd32, TYPE_MEM, 32'h8000_0000};
		next_setup[5] = {6'd63, TYPE_IO, 32'hFFFF_FFFF};
		load_setting();

		// Every guest bit set, then each BAR read back whole.
		for (int s = 0; s < BAR_SLOTS; s++) begin
			send(access_of(CMD_WRITE, WINDOW_BASE[7:0] + 8'(4 * s), 3'd4, 32'hFFFF_FFFF));
		end
		for (int s = 0; s < BAR_SLOTS; s++) begin
			send(access_of(CMD_READ, WINDOW_BASE[7:0] + 8'(4 * s), 3'd4, '0));
		end

		// Window edges: below the window, the top offset with the largest
		// size field, just past the end, and an access that runs past the end.
		send(access_of(CMD_READ, 8'h00, 3'd1, '0));
		send(access_of(CMD_WRITE, 8'hFF, 3'd7, 32'hFFFF_FFFF));
		send(access_of(CMD_READ, 8'h28, 3'd1, '0));
		send(access_of(CMD_READ, 8'h25, 3'd4, '0));
		// Ends exactly at the window end, so it is served.
		send(access_of(CMD_WRITE, 8'h24, 3'd4, 32'h0000_0000));
		// An unaligned write whose top byte would spill into the next BAR; both
		// BARs are read back to show the spilled byte went nowhere.
		send(access_of(CMD_WRITE, 8'h11, 3'd4, 32'h0000_0000));
		send(access_of(CMD_READ, 8'h12, 3'd4, '0));
		send(access_of(CMD_READ, 8'h14, 3'd4, '0));
		// Empty accesses move nothing.
		send(access_of(CMD_WRITE, 8'h18, 3'd0, 32'h0000_0000));
		send(access_of(CMD_READ, 8'h19, 3'd0, '0));
		// An oversized access counts as four bytes.
		send(access_of(CMD_READ, 8'h1C, 3'd6, '0));

		// Random part: two settings in each back-pressure phase. Now and then
		// the sender waits for every answer before going on.
		for (int p = 0; p < SETTING_COUNT; p++) begin
			if (p == 2) begin
				send_idle_pct = 47;
				rcv_idle_pct = 11;
			end
			if (p == 4) begin
				send_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			pick_setting(p);
			load_setting();
			for (int k = 0; k < ACCESSES_PER_SETTING; k++) begin
				if ($urandom_range(99) == 0) begin
					drain();
				end
				send(random_access());
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
